// ===== rtl/sidc_pkg.sv =====
// Shared constants and types for the signed integer to decimal text unit.
`default_nettype none
package sidc_pkg;

   localparam int NUM_W         = 64;
   localparam int DIGITS        = 19;
   localparam int BCD_W         = DIGITS * 4;
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = NUM_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEPS);
   localparam int IDX_W         = $clog2(DIGITS + 1);
   localparam int CHAR_W        = 6;
   localparam int LEN_W         = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic running;
      logic done;
   } conv_status_type;

endpackage
`default_nettype wire

// ===== rtl/sidc_dabble.sv =====
// Iterative binary to BCD converter, four bits per cycle, with significant digit count.
`default_nettype none
module sidc_dabble (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           load,
   input  wire  [sidc_pkg::NUM_W-1:0]    mag,
   output logic [sidc_pkg::BCD_W-1:0]    bcd,
   output logic [sidc_pkg::IDX_W-1:0]    ndig,
   output sidc_pkg::conv_status_type     status
);
   import sidc_pkg::*;

   logic [NUM_W-1:0]  bin_ff,  bin_in;
   logic [BCD_W-1:0]  bcd_ff,  bcd_in;
   logic [IDX_W-1:0]  nd_ff,   nd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff,  run_in;
   logic              done_ff, done_in;

   // Four dependent add-3 / shift steps in combinational logic; each digit corrected in parallel.
   always_comb begin
      logic [BCD_W-1:0] b;
      logic [NUM_W-1:0] s;
      logic [IDX_W-1:0] n;
      logic [3:0]       dg;
      b = bcd_ff;
      s = bin_ff;
      n = nd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         for (int d = 0; d < DIGITS; d++) begin
            dg = b[d*4 +: 4];
            if (dg >= 4'd5) begin
               b[d*4 +: 4] = dg + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], s[NUM_W-1]};
         s = {s[NUM_W-2:0], 1'b0};
         // doubling raises the top nonzero digit by at most one place
         if (n < IDX_W'(DIGITS)) begin
            if (b[{n, 2'b00} +: 4] != 4'd0) begin
               n = n + 1'b1;
            end
         end
      end

      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      nd_in   = nd_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         bin_in  = mag;
         bcd_in  = '0;
         nd_in   = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         bin_in  = s;
         bcd_in  = b;
         nd_in   = n;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      nd_ff  <= nd_in;
   end

   assign bcd            = bcd_ff;
   assign ndig           = nd_ff;
   assign status.running = run_ff;
   assign status.done    = done_ff;

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Top level: renders a signed 64-bit integer as decimal ASCII, one character per strobe.
//
//  channel   ports                                           handshake
//  request   req_number                                      start & !busy
//  response  rsp_character, rsp_text_length, rsp_is_last     rsp_valid, one cycle
//
// A new number is taken only once the previous text has been emitted: after
// the load, the conversion runs in the add-3/shift unit (4 bits per step), the
// text is sized, then one character is emitted per cycle.
// Synchronous active-high reset returns to idle; no response is pending after it.
// The receiver cannot stall; each word is valid for exactly one cycle.
`default_nettype none
module signed_int_to_decimal_ascii_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  signed [sidc_pkg::NUM_W-1:0] req_number,
   output logic                            rsp_valid,
   output logic [sidc_pkg::CHAR_W-1:0]     rsp_character,
   output logic [sidc_pkg::LEN_W-1:0]      rsp_text_length,
   output logic                            rsp_is_last
);
   import sidc_pkg::*;

   state_type         state_ff, state_in;
   logic              neg_ff,   neg_in;
   logic              sign_ff,  sign_in;
   logic [IDX_W-1:0]  idx_ff,   idx_in;
   logic [LEN_W-1:0]  len_ff,   len_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff,  char_in;
   logic [LEN_W-1:0]  tlen_ff,  tlen_in;
   logic              last_ff,  last_in;

   logic              accept;
   logic [NUM_W-1:0]  mag;
   logic [BCD_W-1:0]  bcd;
   logic [IDX_W-1:0]  ndig;
   logic [IDX_W-1:0]  nd_fix;
   logic [3:0]        digit;
   conv_status_type   conv_status;

   assign accept = start && (state_ff == ST_IDLE);
   assign mag    = req_number[NUM_W-1] ? (~req_number + 1'b1) : req_number;

   sidc_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .mag    (mag),
      .bcd    (bcd),
      .ndig   (ndig),
      .status (conv_status)
   );

   // zero leaves no significant digit but still prints one
   assign nd_fix = (ndig == '0) ? IDX_W'(1) : ndig;
   assign digit  = bcd[{idx_ff, 2'b00} +: 4];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (conv_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!sign_ff && idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      neg_in   = neg_ff;
      sign_in  = sign_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      valid_in = 1'b0;
      char_in  = char_ff;
      tlen_in  = tlen_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in = req_number[NUM_W-1];
            end
         end
         ST_CONVERT: begin
            if (conv_status.done) begin
               idx_in  = nd_fix - 1'b1;
               len_in  = LEN_W'(nd_fix) + LEN_W'(neg_ff);
               sign_in = neg_ff;
            end
         end
         ST_EMIT: begin
            valid_in = 1'b1;
            tlen_in  = len_ff;
            if (sign_ff) begin
               char_in = CHAR_MINUS;
               last_in = 1'b0;
               sign_in = 1'b0;
            end else begin
               char_in = CHAR_ZERO + {2'b00, digit};
               last_in = (idx_ff == '0);
               if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         sign_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         sign_ff  <= sign_in;
      end
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      char_ff <= char_in;
      tlen_ff <= tlen_in;
      last_ff <= last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_character   = char_ff;
   assign rsp_text_length = tlen_ff;
   assign rsp_is_last     = last_ff;

endmodule
`default_nettype wire
